[hw/rtl/gru_pkg.sv]
package gru_pkg;

  // Frame geometry
  localparam int SRC_WIDTH  = 160;
  localparam int SRC_HEIGHT = 144;
  localparam int LINE_LEN   = (SRC_WIDTH / 2) * 3;

  localparam int PIX_W  = 16;
  localparam int COL_W  = $clog2(SRC_WIDTH);
  localparam int ROW_W  = $clog2(SRC_HEIGHT);
  localparam int ADDR_W = $clog2(LINE_LEN);
  localparam int XW     = (ADDR_W > 8) ? ADDR_W : 8;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Row phase within a group of three source rows
  localparam logic [1:0] PH_TOP = 2'd0;
  localparam logic [1:0] PH_MID = 2'd1;
  localparam logic [1:0] PH_BOT = 2'd2;

  // One odd-column word: the pixel pair and where its results land
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [XW-1:0]    x0;
    logic [7:0]       y0;
    logic [1:0]       phase;
  } cmd_t;

  // One result slot moving down the back-end pipeline
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [1:0]       k;
    logic             mix;
    logic             up_heavy;
    logic             wr;
    logic             last;
    logic [XW-1:0]    x;
    logic [7:0]       y;
  } slot_t;

  // Weighted linear-light sums per channel
  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } sum3_t;

  // 5-bit code to linear light
  localparam logic [7:0] LIN5 [32] = '{
    8'd0,   8'd0,   8'd1,   8'd1,   8'd3,   8'd5,   8'd7,   8'd10,
    8'd13,  8'd17,  8'd21,  8'd26,  8'd32,  8'd38,  8'd44,  8'd52,
    8'd60,  8'd68,  8'd77,  8'd87,  8'd97,  8'd108, 8'd120, 8'd132,
    8'd145, 8'd159, 8'd173, 8'd188, 8'd204, 8'd220, 8'd237, 8'd255
  };

  // 6-bit code to linear light
  localparam logic [7:0] LIN6 [64] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd3,   8'd4,   8'd4,   8'd5,   8'd7,   8'd8,   8'd9,   8'd11,
    8'd13,  8'd14,  8'd16,  8'd18,  8'd20,  8'd23,  8'd25,  8'd28,
    8'd31,  8'd33,  8'd36,  8'd40,  8'd43,  8'd46,  8'd50,  8'd54,
    8'd57,  8'd61,  8'd66,  8'd70,  8'd74,  8'd79,  8'd84,  8'd89,
    8'd94,  8'd99,  8'd105, 8'd110, 8'd116, 8'd122, 8'd128, 8'd134,
    8'd140, 8'd147, 8'd153, 8'd160, 8'd167, 8'd174, 8'd182, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd221, 8'd229, 8'd238, 8'd246, 8'd255
  };

  // Linear light back to a 5-bit code
  localparam logic [4:0] INV5 [256] = '{
    5'd0,  5'd2,  5'd3,  5'd4,  5'd5,  5'd5,  5'd6,  5'd6,
    5'd6,  5'd7,  5'd7,  5'd7,  5'd8,  5'd8,  5'd8,  5'd9,
    5'd9,  5'd9,  5'd9,  5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd12,
    5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13,
    5'd13, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14,
    5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17,
    5'd17, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
    5'd18, 5'd18, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20, 5'd20,
    5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd21,
    5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
    5'd21, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22,
    5'd22, 5'd22, 5'd22, 5'd22, 5'd22, 5'd22, 5'd23, 5'd23,
    5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd23, 5'd23, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
    5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
    5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25,
    5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd26, 5'd26,
    5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26,
    5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd27, 5'd27, 5'd27, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd29, 5'd29, 5'd29, 5'd29,
    5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29,
    5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd30, 5'd30, 5'd30,
    5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
    5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd31,
    5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31
  };

  // Linear light back to a 6-bit code
  localparam logic [5:0] INV6 [256] = '{
    6'd0,  6'd5,  6'd7,  6'd8,  6'd10, 6'd11, 6'd11, 6'd12,
    6'd13, 6'd14, 6'd14, 6'd15, 6'd16, 6'd16, 6'd17, 6'd17,
    6'd18, 6'd18, 6'd19, 6'd19, 6'd20, 6'd20, 6'd21, 6'd21,
    6'd22, 6'd22, 6'd22, 6'd23, 6'd23, 6'd23, 6'd24, 6'd24,
    6'd25, 6'd25, 6'd25, 6'd26, 6'd26, 6'd26, 6'd27, 6'd27,
    6'd27, 6'd27, 6'd28, 6'd28, 6'd28, 6'd29, 6'd29, 6'd29,
    6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31, 6'd31,
    6'd32, 6'd32, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd33,
    6'd34, 6'd34, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd35,
    6'd35, 6'd36, 6'd36, 6'd36, 6'd36, 6'd37, 6'd37, 6'd37,
    6'd37, 6'd37, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38, 6'd39,
    6'd39, 6'd39, 6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd40,
    6'd40, 6'd41, 6'd41, 6'd41, 6'd41, 6'd41, 6'd42, 6'd42,
    6'd42, 6'd42, 6'd42, 6'd42, 6'd43, 6'd43, 6'd43, 6'd43,
    6'd43, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd45,
    6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd46, 6'd46, 6'd46,
    6'd46, 6'd46, 6'd46, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47,
    6'd47, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48,
    6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd50,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd51, 6'd51, 6'd51,
    6'd51, 6'd51, 6'd51, 6'd51, 6'd52, 6'd52, 6'd52, 6'd52,
    6'd52, 6'd52, 6'd52, 6'd53, 6'd53, 6'd53, 6'd53, 6'd53,
    6'd53, 6'd53, 6'd54, 6'd54, 6'd54, 6'd54, 6'd54, 6'd54,
    6'd54, 6'd54, 6'd55, 6'd55, 6'd55, 6'd55, 6'd55, 6'd55,
    6'd55, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56, 6'd56,
    6'd56, 6'd57, 6'd57, 6'd57, 6'd57, 6'd57, 6'd57, 6'd57,
    6'd57, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58,
    6'd58, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59,
    6'd59, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60,
    6'd60, 6'd60, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61,
    6'd61, 6'd61, 6'd62, 6'd62, 6'd62, 6'd62, 6'd62, 6'd62,
    6'd62, 6'd62, 6'd62, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63
  };

  // Weighted sum per channel: p and q once each, plus the heavy one again
  function automatic sum3_t blend_sum(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q,
                                      logic heavy_p);
    logic [7:0] pr, pg, pb, qr, qg, qb;
    sum3_t s;
    pr = LIN5[p[15:11]];
    pg = LIN6[p[10:5]];
    pb = LIN5[p[4:0]];
    qr = LIN5[q[15:11]];
    qg = LIN6[q[10:5]];
    qb = LIN5[q[4:0]];
    s.r = {2'b00, pr} + {2'b00, qr} + {2'b00, (heavy_p ? pr : qr)};
    s.g = {2'b00, pg} + {2'b00, qg} + {2'b00, (heavy_p ? pg : qg)};
    s.b = {2'b00, pb} + {2'b00, qb} + {2'b00, (heavy_p ? pb : qb)};
    return s;
  endfunction

  // Floor of v/3 for v up to 765, by reciprocal multiply
  function automatic logic [7:0] div3(logic [9:0] v);
    logic [19:0] prod;
    prod = {10'd0, v} * 20'd683;
    return prod[18:11];
  endfunction

  // Divide each channel sum by three and map back to RGB565
  function automatic logic [PIX_W-1:0] blend_fin(sum3_t s);
    return {INV5[div3(s.r)], INV6[div3(s.g)], INV5[div3(s.b)]};
  endfunction

endpackage

[hw/rtl/gru_in_if.sv]
interface gru_in_if;
  logic                       valid;
  logic                       ready;
  logic [gru_pkg::PIX_W-1:0]  pixel_in;
  logic                       frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

[hw/rtl/gru_out_if.sv]
interface gru_out_if;
  logic                       valid;
  logic                       ready;
  logic [gru_pkg::PIX_W-1:0]  pixel_out;
  logic [7:0]                 out_x;
  logic [7:0]                 out_y;
  logic                       run_last;

  modport source (output valid, output pixel_out, output out_x, output out_y,
                  output run_last, input ready);
  modport sink (input valid, input pixel_out, input out_x, input out_y,
                input run_last, output ready);
endinterface

[hw/rtl/gru_ram.sv]
module gru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 240
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port; registered read returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[hw/rtl/gru_fifo.sv]
module gru_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gru_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output gru_pkg::cmd_t head
);
  import gru_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end
endmodule

[hw/rtl/gru_front.sv]
module gru_front (
  input  logic          clk,
  input  logic          rst_n,
  gru_in_if.sink        in_if,
  input  logic          q_full,
  output logic          q_push,
  output gru_pkg::cmd_t q_cmd
);
  import gru_pkg::*;

  logic [COL_W-1:0] col_r, col_e, col_nxt;
  logic [ROW_W-1:0] row_r, row_e, row_nxt;
  logic [1:0]       ph_r, ph_e, ph_nxt;
  logic [XW-1:0]    xb_r, xb_e, xb_nxt;
  logic [7:0]       yb_r, yb_e, yb_nxt;
  logic [PIX_W-1:0] pend_r;
  logic             acc, odd, col_end, row_end;

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && in_if.ready;

  // Frame start forces position zero for this word
  assign col_e = in_if.frame_start ? '0 : col_r;
  assign row_e = in_if.frame_start ? '0 : row_r;
  assign ph_e  = in_if.frame_start ? PH_TOP : ph_r;
  assign xb_e  = in_if.frame_start ? '0 : xb_r;
  assign yb_e  = in_if.frame_start ? '0 : yb_r;

  assign odd     = col_e[0];
  assign col_end = (col_e == COL_W'(SRC_WIDTH - 1));
  assign row_end = (row_e == ROW_W'(SRC_HEIGHT - 1));

  // Odd column: hand the pair to the back end
  assign q_push = acc && odd;
  assign q_cmd  = '{a: pend_r, b: in_if.pixel_in, x0: xb_e, y0: yb_e, phase: ph_e};

  // Next position after this word
  always_comb begin
    col_nxt = col_e + COL_W'(1);
    xb_nxt  = odd ? xb_e + XW'(3) : xb_e;
    row_nxt = row_e;
    ph_nxt  = ph_e;
    yb_nxt  = yb_e;
    if (col_end) begin
      col_nxt = '0;
      xb_nxt  = '0;
      if (row_end) begin
        row_nxt = '0;
        ph_nxt  = PH_TOP;
        yb_nxt  = '0;
      end else begin
        row_nxt = row_e + ROW_W'(1);
        if (ph_e == PH_BOT) begin
          ph_nxt = PH_TOP;
          yb_nxt = yb_e + 8'd5;
        end else begin
          ph_nxt = ph_e + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ph_r  <= PH_TOP;
      xb_r  <= '0;
      yb_r  <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ph_r  <= ph_nxt;
      xb_r  <= xb_nxt;
      yb_r  <= yb_nxt;
    end
  end

  // Hold the even pixel until its partner arrives
  always_ff @(posedge clk) begin
    if (acc && !odd) begin
      pend_r <= in_if.pixel_in;
    end
  end
endmodule

[hw/rtl/gru_back.sv]
module gru_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  gru_pkg::cmd_t q_cmd,
  output logic          q_pop,
  gru_out_if.source     out_if
);
  import gru_pkg::*;

  localparam logic [2:0] SLOT_MIX0   = 3'd0;
  localparam logic [2:0] SLOT_PLAIN0 = 3'd3;
  localparam logic [2:0] SLOT_LAST   = 3'd5;

  logic             cur_v_r;
  cmd_t             cur_r;
  logic [2:0]       idx_r;
  slot_t            slot;
  logic [1:0]       k;
  logic             mix;
  logic [7:0]       yoff;
  logic             hazard, issue, advance;

  logic             p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  slot_t            p1_r, p2_r, p3_r, p4_r;
  sum3_t            hsum, p2_sum_r, vsum, p4_sum_r;
  logic [PIX_W-1:0] ram_rdata, p2_up_r, h, p3_h_r, p3_up_r, p4_h_r, res_pix;

  logic             out_v_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [7:0]       out_x_r, out_y_r;
  logic             out_last_r;

  assign advance = !out_v_r || out_if.ready;

  // Build the slot for the current step of the word
  assign mix = (idx_r < SLOT_PLAIN0);
  assign k   = mix ? idx_r[1:0] : 2'(idx_r - SLOT_PLAIN0);

  always_comb begin
    case (cur_r.phase)
      PH_MID:  yoff = mix ? 8'd1 : 8'd2;
      PH_BOT:  yoff = mix ? 8'd3 : 8'd4;
      default: yoff = 8'd0;
    endcase
  end

  assign slot = '{a: cur_r.a, b: cur_r.b, k: k, mix: mix,
                  up_heavy: (cur_r.phase == PH_MID), wr: !mix,
                  last: (idx_r == SLOT_LAST), x: cur_r.x0 + XW'(k),
                  y: cur_r.y0 + yoff};

  // Hold a mixed read until older writes to the same entry have landed
  assign hazard = mix && ((p1_v_r && p1_r.wr && (p1_r.x == slot.x)) ||
                          (p2_v_r && p2_r.wr && (p2_r.x == slot.x)));
  assign issue  = cur_v_r && advance && !hazard;
  assign q_pop  = q_valid && (!cur_v_r || (issue && (idx_r == SLOT_LAST)));

  // Step through the slots of the current word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= SLOT_MIX0;
    end else if (q_pop) begin
      cur_v_r <= 1'b1;
      idx_r   <= (q_cmd.phase == PH_TOP) ? SLOT_PLAIN0 : SLOT_MIX0;
    end else if (issue) begin
      if (idx_r == SLOT_LAST) begin
        cur_v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
  end

  // Previous scaled line
  gru_ram #(.WIDTH(PIX_W), .DEPTH(LINE_LEN)) u_line (
    .clk   (clk),
    .we    (p2_v_r && p2_r.wr),
    .waddr (p2_r.x[ADDR_W-1:0]),
    .wdata (h),
    .re    (issue && mix),
    .raddr (slot.x[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Horizontal blend, then vertical blend
  assign hsum    = blend_sum(p1_r.a, p1_r.b, (p1_r.k == 2'd1));
  assign h       = (p2_r.k == 2'd0) ? p2_r.a : blend_fin(p2_sum_r);
  assign vsum    = blend_sum(p3_up_r, p3_h_r, p3_r.up_heavy);
  assign res_pix = p4_r.mix ? blend_fin(p4_sum_r) : p4_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      p1_v_r  <= issue;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      p4_v_r  <= p3_v_r;
      out_v_r <= p4_v_r;
    end
  end

  // Move payloads along with the valid bits
  always_ff @(posedge clk) begin
    if (advance) begin
      p1_r       <= slot;
      p2_r       <= p1_r;
      p2_sum_r   <= hsum;
      p2_up_r    <= ram_rdata;
      p3_r       <= p2_r;
      p3_h_r     <= h;
      p3_up_r    <= p2_up_r;
      p4_r       <= p3_r;
      p4_h_r     <= p3_h_r;
      p4_sum_r   <= vsum;
      out_pix_r  <= res_pix;
      out_x_r    <= p4_r.x[7:0];
      out_y_r    <= p4_r.y;
      out_last_r <= p4_r.last;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.pixel_out = out_pix_r;
  assign out_if.out_x     = out_x_r;
  assign out_if.out_y     = out_y_r;
  assign out_if.run_last  = out_last_r;
endmodule

[hw/rtl/gamma_aware_rgb565_upscaler.sv]
// An odd-column word passes the queue, current-word register, stages p1 to p4
// and output register to its first result. The back end issues one result per
// cycle unless the output port stalls or a line-store hazard holds it: six per
// pixel pair on blended rows, three elsewhere, none for an even-column word.
// Reset (rst_n low, synchronous) clears counters, queue and pipeline valids;
// the line store and pending pixel are not cleared and need no clearing pass.
module gamma_aware_rgb565_upscaler (
  input logic        clk,
  input logic        rst_n,
  gru_in_if.sink     in_if,
  gru_out_if.source  out_if
);
  import gru_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_in, q_head;

  // Accept and sort source pixels
  gru_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  // Decouple front and back
  gru_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Blend and emit result words
  gru_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );
endmodule
